// ----- rtl/core/pidsl_pkg.sv -----
// ---------------------------------------------------------------------------
// pidsl_pkg
// Types and constants shared by the position loop with soft limits.
// ---------------------------------------------------------------------------
package pidsl_pkg;

  localparam int QDEPTH       = 2;
  localparam int POLAR_MARGIN = 512;

  typedef enum logic [3:0] {
    REG_KP_GAIN       = 4'd0,
    REG_KI_GAIN       = 4'd1,
    REG_KD_GAIN       = 4'd2,
    REG_INTEGRAL_ZONE = 4'd3,
    REG_MIN_OUTPUT    = 4'd4,
    REG_MAX_OUTPUT    = 4'd5,
    REG_FRONT_LIMIT   = 4'd6,
    REG_BACK_LIMIT    = 4'd7
  } reg_index_t;

  localparam logic signed [15:0] MIN_OUTPUT_RST  = 16'sh8000;
  localparam logic signed [15:0] MAX_OUTPUT_RST  = 16'sh7FFF;
  localparam logic        [14:0] FRONT_LIMIT_RST = 15'd25600;
  localparam logic        [14:0] BACK_LIMIT_RST  = 15'd0;

  typedef struct packed {
    logic [14:0] target_position;
    logic [14:0] measured_position;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] motor_power;
    logic signed [15:0] commanded_power;
    logic               limit_blocked;
    logic               near_front;
    logic               near_back;
    logic               polarized;
  } out_item_t;

  typedef struct packed {
    logic [3:0]  index;
    logic [15:0] wdata;
  } cfg_item_t;

  typedef struct packed {
    logic signed [15:0] kp_gain;
    logic signed [15:0] ki_gain;
    logic signed [15:0] kd_gain;
    logic        [14:0] integral_zone;
    logic signed [15:0] min_output;
    logic signed [15:0] max_output;
    logic        [14:0] front_limit;
    logic        [14:0] back_limit;
  } cfg_regs_t;

  typedef struct packed {
    logic near_front;
    logic near_back;
    logic polarized;
    logic pos_ge_back;
    logic pos_le_front;
  } pos_flags_t;

  typedef struct packed {
    logic signed [15:0] err;
    logic signed [16:0] derr;
    logic        [14:0] target;
    logic               zone_ok;
    pos_flags_t         flags;
  } cls_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_sts_t;

  typedef struct packed {
    logic adv;
    logic pop;
  } back_sts_t;

endpackage

// ----- rtl/core/pidsl_chan_if.sv -----
// ---------------------------------------------------------------------------
// pidsl_chan_if
// Valid/ready channel carrying one payload per transaction.
// ---------------------------------------------------------------------------
interface pidsl_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/pid_position_loop_soft_limits.sv -----
// ---------------------------------------------------------------------------
// pid_position_loop_soft_limits
// PID position loop with integral zone, setpoint feedforward, output clamp
// and soft-limit gating of the motor drive.
// ---------------------------------------------------------------------------
//   Channel  Direction  Payload
//   in_ch    sink       target_position, measured_position
//   out_ch   source     motor_power, commanded_power, limit_blocked, flags
//   cfg_ch   sink       register index, write data
//
// One sample is accepted per cycle while the queue is not full. Its result
// passes through the queue, then the product and integrator stages, then the
// clamp and gating stage, which registers the result. The integrator loop is
// one add and saturate per cycle while the pipeline advances.
// A two-entry queue parts front and back, so up to two samples are taken
// while a result waits. Reset is synchronous and clears the integrator and
// the previous error. Configuration writes complete in the cycle they are
// offered.
// ---------------------------------------------------------------------------
module pid_position_loop_soft_limits #(
  parameter int FEEDFORWARD_GAIN = 0,
  parameter int NEAR_SPAN        = 1280
) (
  input  logic         clk,
  input  logic         rst_n,
  pidsl_chan_if.sink   in_ch,
  pidsl_chan_if.source out_ch,
  pidsl_chan_if.sink   cfg_ch
);

  pidsl_pkg::cfg_regs_t  cfg;
  pidsl_pkg::q_sts_t     q_sts;
  pidsl_pkg::back_sts_t  b_sts;
  pidsl_pkg::cls_item_t  push_item;
  pidsl_pkg::cls_item_t  head_item;
  logic                  push;

  pidsl_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  pidsl_front #(
    .NEAR_SPAN (NEAR_SPAN)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg       (cfg),
    .q_sts     (q_sts),
    .push      (push),
    .push_item (push_item)
  );

  pidsl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (b_sts.pop),
    .head_item (head_item),
    .q_sts     (q_sts)
  );

  pidsl_back #(
    .FEEDFORWARD_GAIN (FEEDFORWARD_GAIN)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .head_item (head_item),
    .q_sts     (q_sts),
    .b_sts     (b_sts),
    .out_ch    (out_ch)
  );

  // The back end never pops an empty queue.
  a_pop_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    b_sts.pop |-> !q_sts.empty)
    else $error("queue popped while empty");

  // The queue fills only while the output is stalled.
  a_full_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(q_sts.full) |-> $past(!b_sts.adv))
    else $error("queue filled while the back end was advancing");

  // Blocked drive means a nonzero command with zero motor power.
  a_blocked : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.data.limit_blocked ==
      ((out_ch.data.commanded_power != '0) && (out_ch.data.motor_power == '0))))
    else $error("limit_blocked inconsistent with drive");

endmodule

// ----- rtl/core/pidsl_cfg_regs.sv -----
// ---------------------------------------------------------------------------
// pidsl_cfg_regs
// Configuration register file written through the configuration channel.
// ---------------------------------------------------------------------------
module pidsl_cfg_regs (
  input  logic                 clk,
  input  logic                 rst_n,
  pidsl_chan_if.sink           cfg_ch,
  output pidsl_pkg::cfg_regs_t cfg
);

  pidsl_pkg::cfg_regs_t cfg_r;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp_gain       <= '0;
      cfg_r.ki_gain       <= '0;
      cfg_r.kd_gain       <= '0;
      cfg_r.integral_zone <= '0;
      cfg_r.min_output    <= pidsl_pkg::MIN_OUTPUT_RST;
      cfg_r.max_output    <= pidsl_pkg::MAX_OUTPUT_RST;
      cfg_r.front_limit   <= pidsl_pkg::FRONT_LIMIT_RST;
      cfg_r.back_limit    <= pidsl_pkg::BACK_LIMIT_RST;
    end else if (cfg_ch.valid) begin
      unique case (pidsl_pkg::reg_index_t'(cfg_ch.data.index))
        pidsl_pkg::REG_KP_GAIN:       cfg_r.kp_gain       <= cfg_ch.data.wdata;
        pidsl_pkg::REG_KI_GAIN:       cfg_r.ki_gain       <= cfg_ch.data.wdata;
        pidsl_pkg::REG_KD_GAIN:       cfg_r.kd_gain       <= cfg_ch.data.wdata;
        pidsl_pkg::REG_INTEGRAL_ZONE: cfg_r.integral_zone <= cfg_ch.data.wdata[14:0];
        pidsl_pkg::REG_MIN_OUTPUT:    cfg_r.min_output    <= cfg_ch.data.wdata;
        pidsl_pkg::REG_MAX_OUTPUT:    cfg_r.max_output    <= cfg_ch.data.wdata;
        pidsl_pkg::REG_FRONT_LIMIT:   cfg_r.front_limit   <= cfg_ch.data.wdata[14:0];
        pidsl_pkg::REG_BACK_LIMIT:    cfg_r.back_limit    <= cfg_ch.data.wdata[14:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/pidsl_front.sv -----
// ---------------------------------------------------------------------------
// pidsl_front
// Accepts samples, forms the error and its difference, and classifies the
// position against the soft limits.
// ---------------------------------------------------------------------------
module pidsl_front #(
  parameter int NEAR_SPAN = 1280
) (
  input  logic                 clk,
  input  logic                 rst_n,
  pidsl_chan_if.sink           in_ch,
  input  pidsl_pkg::cfg_regs_t cfg,
  input  pidsl_pkg::q_sts_t    q_sts,
  output logic                 push,
  output pidsl_pkg::cls_item_t push_item
);

  localparam logic signed [17:0] RANGE_S  = 18'(NEAR_SPAN);
  localparam logic signed [17:0] MARGIN_S = 18'(pidsl_pkg::POLAR_MARGIN);

  logic signed [15:0] prev_err_r;
  logic signed [15:0] err;
  logic        [15:0] aerr;
  logic signed [17:0] pos_s;
  logic signed [17:0] front_s;
  logic signed [17:0] back_s;

  assign in_ch.ready = !q_sts.full;
  assign push        = in_ch.valid && !q_sts.full;

  always_comb begin
    err     = $signed({1'b0, in_ch.data.target_position})
            - $signed({1'b0, in_ch.data.measured_position});
    aerr    = err[15] ? 16'(-err) : 16'(err);
    pos_s   = $signed({3'b000, in_ch.data.measured_position});
    front_s = $signed({3'b000, cfg.front_limit});
    back_s  = $signed({3'b000, cfg.back_limit});

    push_item.err     = err;
    push_item.derr    = $signed({err[15], err}) - $signed({prev_err_r[15], prev_err_r});
    push_item.target  = in_ch.data.target_position;
    push_item.zone_ok = (cfg.integral_zone == '0) || (aerr <= {1'b0, cfg.integral_zone});
    push_item.flags.near_front   = pos_s > (front_s - RANGE_S);
    push_item.flags.near_back    = pos_s < (back_s + RANGE_S);
    push_item.flags.polarized    = (pos_s > (front_s - MARGIN_S))
                                 || (pos_s < (back_s + MARGIN_S));
    push_item.flags.pos_ge_back  = in_ch.data.measured_position >= cfg.back_limit;
    push_item.flags.pos_le_front = in_ch.data.measured_position <= cfg.front_limit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_err_r <= '0;
    end else if (push) begin
      prev_err_r <= err;
    end
  end

endmodule

// ----- rtl/core/pidsl_queue.sv -----
// ---------------------------------------------------------------------------
// pidsl_queue
// Short FIFO that decouples the classifying front from the arithmetic back.
// ---------------------------------------------------------------------------
module pidsl_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  pidsl_pkg::cls_item_t push_item,
  input  logic                 pop,
  output pidsl_pkg::cls_item_t head_item,
  output pidsl_pkg::q_sts_t    q_sts
);

  localparam int PW = (pidsl_pkg::QDEPTH > 1) ? $clog2(pidsl_pkg::QDEPTH) : 1;
  localparam int CW = $clog2(pidsl_pkg::QDEPTH + 1);

  pidsl_pkg::cls_item_t entry_r [pidsl_pkg::QDEPTH];
  logic [PW-1:0]        wr_ptr_r;
  logic [PW-1:0]        rd_ptr_r;
  logic [CW-1:0]        count_r;

  assign head_item   = entry_r[rd_ptr_r];
  assign q_sts.full  = count_r == CW'(pidsl_pkg::QDEPTH);
  assign q_sts.empty = count_r == '0;

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(pidsl_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(pidsl_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/pidsl_back.sv -----
// ---------------------------------------------------------------------------
// pidsl_back
// Gain multiplies, integrator, clamp, negation and soft-limit gating in a
// three-stage pipeline that stalls as a whole on output backpressure.
// ---------------------------------------------------------------------------
module pidsl_back #(
  parameter int FEEDFORWARD_GAIN = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pidsl_pkg::cfg_regs_t cfg,
  input  pidsl_pkg::cls_item_t head_item,
  input  pidsl_pkg::q_sts_t    q_sts,
  output pidsl_pkg::back_sts_t b_sts,
  pidsl_chan_if.source         out_ch
);

  localparam logic signed [15:0] FF_GAIN = 16'(FEEDFORWARD_GAIN);
  localparam logic signed [32:0] I32_MAX = 33'sh0_7FFF_FFFF;
  localparam logic signed [32:0] I32_MIN = -33'sh0_8000_0000;

  logic adv;
  logic pop;

  // Stage A: products.
  logic                  valid_a_r;
  logic signed [31:0]    p_a_r;
  logic signed [31:0]    i_a_r;
  logic signed [32:0]    d_a_r;
  logic signed [31:0]    f_a_r;
  logic                  zone_a_r;
  pidsl_pkg::pos_flags_t flags_a_r;
  logic signed [31:0]    p_nxt;
  logic signed [31:0]    i_nxt;
  logic signed [32:0]    d_nxt;
  logic signed [31:0]    f_nxt;

  // Stage B: integrator and partial sum.
  logic                  valid_b_r;
  logic signed [31:0]    integ_r;
  logic signed [31:0]    integ_nxt;
  logic signed [32:0]    integ_sum;
  logic signed [31:0]    i_half;
  logic signed [33:0]    pdf_b_r;
  logic signed [33:0]    pdf_nxt;
  pidsl_pkg::pos_flags_t flags_b_r;

  // Stage C: total, clamp, negate, gate.
  logic                  out_valid_r;
  pidsl_pkg::out_item_t  out_data_r;
  pidsl_pkg::out_item_t  out_nxt;
  logic signed [34:0]    total;
  logic signed [34:0]    lo_clamp;
  logic signed [34:0]    hi_clamp;
  logic signed [15:0]    clamped;
  logic signed [16:0]    neg;
  logic signed [15:0]    cmd;

  assign adv          = !out_valid_r || out_ch.ready;
  assign pop          = adv && !q_sts.empty;
  assign b_sts.adv    = adv;
  assign b_sts.pop    = pop;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  always_comb begin
    p_nxt = cfg.kp_gain * head_item.err;
    i_nxt = cfg.ki_gain * head_item.err;
    d_nxt = cfg.kd_gain * head_item.derr;
    f_nxt = FF_GAIN * $signed({1'b0, head_item.target});
  end

  always_comb begin
    i_half    = i_a_r >>> 1;
    integ_sum = 33'(integ_r) + 33'(i_half);
    if (!zone_a_r) begin
      integ_nxt = '0;
    end else if (integ_sum > I32_MAX) begin
      integ_nxt = I32_MAX[31:0];
    end else if (integ_sum < I32_MIN) begin
      integ_nxt = I32_MIN[31:0];
    end else begin
      integ_nxt = integ_sum[31:0];
    end
    pdf_nxt = 34'(p_a_r >>> 1) + 34'(d_a_r >>> 1) + 34'(f_a_r >>> 1);
  end

  always_comb begin
    total    = 35'(pdf_b_r) + 35'(integ_r);
    lo_clamp = (total < 35'(cfg.min_output)) ? 35'(cfg.min_output) : total;
    hi_clamp = (lo_clamp > 35'(cfg.max_output)) ? 35'(cfg.max_output) : lo_clamp;
    clamped  = hi_clamp[15:0];
    neg      = -17'(clamped);
    cmd      = (neg > 17'sd32767) ? 16'sh7FFF : neg[15:0];

    out_nxt.commanded_power = cmd;
    if (cmd > 16'sd0) begin
      out_nxt.motor_power = flags_b_r.pos_ge_back ? cmd : '0;
    end else if (cmd < 16'sd0) begin
      out_nxt.motor_power = flags_b_r.pos_le_front ? cmd : '0;
    end else begin
      out_nxt.motor_power = '0;
    end
    out_nxt.limit_blocked = (cmd != '0) && (out_nxt.motor_power == '0);
    out_nxt.near_front    = flags_b_r.near_front;
    out_nxt.near_back     = flags_b_r.near_back;
    out_nxt.polarized     = flags_b_r.polarized;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r   <= 1'b0;
      valid_b_r   <= 1'b0;
      out_valid_r <= 1'b0;
      integ_r     <= '0;
    end else if (adv) begin
      valid_a_r   <= pop;
      valid_b_r   <= valid_a_r;
      out_valid_r <= valid_b_r;
      if (valid_a_r) begin
        integ_r <= integ_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_a_r      <= p_nxt;
      i_a_r      <= i_nxt;
      d_a_r      <= d_nxt;
      f_a_r      <= f_nxt;
      zone_a_r   <= head_item.zone_ok;
      flags_a_r  <= head_item.flags;
      pdf_b_r    <= pdf_nxt;
      flags_b_r  <= flags_a_r;
      out_data_r <= out_nxt;
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the PID position loop with soft limits. A short
// table of directed samples and register writes covers the gain, clamp,
// negation and soft-limit corner cases. Randomized phases with fresh
// settings follow. Each result is checked against the table's expected value,
// or else a cycle-free loop model that tracks the integrator and previous error.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int FF_GAIN   = 0;
  localparam int NEAR_SPAN = 1280;
  localparam logic [3:0] TOP_REG_CODE = 4'hF;

  typedef enum logic {ROW_REG, ROW_SAMPLE} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [3:0]            idx;
    logic [15:0]           wdata;
    pidsl_pkg::in_item_t   smp;
    bit                    fixed;
    pidsl_pkg::out_item_t  want;
  } plan_row_t;

  typedef struct {
    bit                   fixed;
    pidsl_pkg::out_item_t want;
  } preset_t;

  logic clk;
  logic rst_n;

  pidsl_chan_if #(.payload_t(pidsl_pkg::in_item_t))  in_if ();
  pidsl_chan_if #(.payload_t(pidsl_pkg::out_item_t)) out_if ();
  pidsl_chan_if #(.payload_t(pidsl_pkg::cfg_item_t)) cfg_if ();

  pid_position_loop_soft_limits #(
    .FEEDFORWARD_GAIN(FF_GAIN),
    .NEAR_SPAN(NEAR_SPAN)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_if.sink),
    .out_ch(out_if.source),
    .cfg_ch(cfg_if.sink)
  );

  pidsl_pkg::cfg_regs_t  regs;
  longint                integ_acc;
  longint                last_err;
  pidsl_pkg::out_item_t  pending_drive[$];
  preset_t               preset_q[$];
  bit                    gaps_on;
  int                    err_count;
  int                    samples_sent;
  int                    drives_checked;
  int                    reg_writes;
  int                    drives_blocked;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic pidsl_pkg::out_item_t loop_step(pidsl_pkg::in_item_t s);
    longint tgt, pos, err, aerr, p, d, f, total, clamped, cmd, motor;
    longint front, back;
    pidsl_pkg::out_item_t r;
    tgt   = longint'(s.target_position);
    pos   = longint'(s.measured_position);
    front = longint'(regs.front_limit);
    back  = longint'(regs.back_limit);
    err   = tgt - pos;
    aerr  = (err < 0) ? -err : err;
    p = (longint'($signed(regs.kp_gain)) * err) >>> 1;
    if (regs.integral_zone == '0 || aerr <= longint'(regs.integral_zone)) begin
      integ_acc = integ_acc + ((longint'($signed(regs.ki_gain)) * err) >>> 1);
      if (integ_acc > 64'sd2147483647) integ_acc = 64'sd2147483647;
      if (integ_acc < -64'sd2147483648) integ_acc = -64'sd2147483648;
    end else begin
      integ_acc = 0;
    end
    d = (longint'($signed(regs.kd_gain)) * (err - last_err)) >>> 1;
    last_err = err;
    f = (longint'(FF_GAIN) * tgt) >>> 1;
    total = p + integ_acc + d + f;
    clamped = (total < longint'($signed(regs.min_output))) ?
              longint'($signed(regs.min_output)) : total;
    if (clamped > longint'($signed(regs.max_output))) begin
      clamped = longint'($signed(regs.max_output));
    end
    cmd = -clamped;
    if (cmd > 32767) cmd = 32767;
    if (cmd > 0) begin
      motor = (pos >= back) ? cmd : 0;
    end else if (cmd < 0) begin
      motor = (pos <= front) ? cmd : 0;
    end else begin
      motor = 0;
    end
    r.motor_power     = 16'(motor);
    r.commanded_power = 16'(cmd);
    r.limit_blocked   = (cmd != 0) && (motor == 0);
    r.near_front      = pos > front - NEAR_SPAN;
    r.near_back       = pos < back + NEAR_SPAN;
    r.polarized       = (pos > front - pidsl_pkg::POLAR_MARGIN) ||
                        (pos < back + pidsl_pkg::POLAR_MARGIN);
    return r;
  endfunction

  function automatic string drive_str(pidsl_pkg::out_item_t r);
    return $sformatf("motor %0d cmd %0d blocked %b front %b back %b polar %b",
                     $signed(r.motor_power), $signed(r.commanded_power),
                     r.limit_blocked, r.near_front, r.near_back, r.polarized);
  endfunction

  task automatic flag_error(string what);
    err_count++;
    if (err_count <= 10) begin
      $display("ERROR at %0t: %s", $realtime, what);
    end
  endtask

  always @(posedge clk) begin : watch
    preset_t              tag;
    pidsl_pkg::out_item_t want;
    pidsl_pkg::out_item_t got;
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) begin
        reg_writes++;
        case (cfg_if.data.index)
          pidsl_pkg::REG_KP_GAIN:       regs.kp_gain       = cfg_if.data.wdata;
          pidsl_pkg::REG_KI_GAIN:       regs.ki_gain       = cfg_if.data.wdata;
          pidsl_pkg::REG_KD_GAIN:       regs.kd_gain       = cfg_if.data.wdata;
          pidsl_pkg::REG_INTEGRAL_ZONE: regs.integral_zone = cfg_if.data.wdata[14:0];
          pidsl_pkg::REG_MIN_OUTPUT:    regs.min_output    = cfg_if.data.wdata;
          pidsl_pkg::REG_MAX_OUTPUT:    regs.max_output    = cfg_if.data.wdata;
          pidsl_pkg::REG_FRONT_LIMIT:   regs.front_limit   = cfg_if.data.wdata[14:0];
          pidsl_pkg::REG_BACK_LIMIT:    regs.back_limit    = cfg_if.data.wdata[14:0];
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        samples_sent++;
        tag  = preset_q.pop_front();
        want = loop_step(in_if.data);
        pending_drive.push_back(tag.fixed ? tag.want : want);
      end
      if (out_if.valid && out_if.ready) begin
        got = out_if.data;
        if (pending_drive.size() == 0) begin
          flag_error($sformatf("unexpected result: %s", drive_str(got)));
        end else begin
          want = pending_drive.pop_front();
          drives_checked++;
          if (got.limit_blocked) drives_blocked++;
          if (got.motor_power !== want.motor_power ||
              got.commanded_power !== want.commanded_power ||
              got.limit_blocked !== want.limit_blocked ||
              got.near_front !== want.near_front ||
              got.near_back !== want.near_back ||
              got.polarized !== want.polarized) begin
            flag_error($sformatf("expected %s, got %s", drive_str(want), drive_str(got)));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    out_if.ready <= !(gaps_on && $urandom_range(0, 99) < 6);
  end

  task automatic put_sample(pidsl_pkg::in_item_t s, bit fixed, pidsl_pkg::out_item_t want);
    preset_t tag;
    while (gaps_on && $urandom_range(0, 99) < 6) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    tag.fixed = fixed;
    tag.want  = want;
    preset_q.push_back(tag);
    in_if.valid <= 1'b1;
    in_if.data  <= s;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic put_reg(logic [3:0] idx, logic [15:0] wd);
    pidsl_pkg::cfg_item_t c;
    while (gaps_on && $urandom_range(0, 99) < 6) begin
      cfg_if.valid <= 1'b0;
      @(posedge clk);
    end
    c.index = idx;
    c.wdata = wd;
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= c;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  task automatic settle();
    in_if.valid  <= 1'b0;
    cfg_if.valid <= 1'b0;
    @(posedge clk);
    while (preset_q.size() != 0 || pending_drive.size() != 0) @(posedge clk);
  endtask

  function automatic plan_row_t reg_row(logic [3:0] idx, logic [15:0] wd);
    plan_row_t r;
    r = '{ROW_REG, idx, wd, '0, 1'b0, '0};
    return r;
  endfunction

  function automatic plan_row_t smp_row(int t, int m);
    plan_row_t r;
    r = '{ROW_SAMPLE, '0, '0, '{15'(t), 15'(m)}, 1'b0, '0};
    return r;
  endfunction

  function automatic plan_row_t chk_row(int t, int m, pidsl_pkg::out_item_t want);
    plan_row_t r;
    r = '{ROW_SAMPLE, '0, '0, '{15'(t), 15'(m)}, 1'b1, want};
    return r;
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom);
      3, 4: return 16'($urandom_range(0, 16)) - 16'd8;
      default: return 16'($urandom_range(0, 1024)) - 16'd512;
    endcase
  endfunction

  function automatic logic [15:0] pick_pos();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'd25600;
      2: return 16'($urandom);
      default: return 16'($urandom_range(0, 25600));
    endcase
  endfunction

  initial begin
    plan_row_t            plan[$];
    row_kind_t            prev_kind;
    pidsl_pkg::in_item_t  s;
    logic [15:0]          fld;
    logic [15:0]          zone;
    int                   tgt;
    int                   spread;
    int                   m;
    int                   lo;
    int                   hi;

    rst_n        <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    gaps_on        = 1'b1;
    err_count      = 0;
    samples_sent   = 0;
    drives_checked = 0;
    reg_writes     = 0;
    drives_blocked = 0;
    regs = '{16'sd0, 16'sd0, 16'sd0, 15'd0,
             pidsl_pkg::MIN_OUTPUT_RST, pidsl_pkg::MAX_OUTPUT_RST,
             pidsl_pkg::FRONT_LIMIT_RST, pidsl_pkg::BACK_LIMIT_RST};
    integ_acc = 0;
    last_err  = 0;

    plan.push_back(chk_row(0, 0, '{16'sd0, 16'sd0, 1'b0, 1'b0, 1'b1, 1'b1}));
    plan.push_back(chk_row(25600, 25600, '{16'sd0, 16'sd0, 1'b0, 1'b1, 1'b0, 1'b1}));
    plan.push_back(chk_row(32767, 32767, '{16'sd0, 16'sd0, 1'b0, 1'b1, 1'b0, 1'b1}));
    plan.push_back(chk_row(12800, 12800, '{16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0, 1'b0}));
    plan.push_back(reg_row(pidsl_pkg::REG_KP_GAIN, 16'h7FFF));
    plan.push_back(chk_row(25600, 0, '{-16'sd32767, -16'sd32767, 1'b0, 1'b0, 1'b1, 1'b1}));
    plan.push_back(chk_row(0, 25600, '{16'sd32767, 16'sd32767, 1'b0, 1'b1, 1'b0, 1'b1}));
    plan.push_back(reg_row(pidsl_pkg::REG_FRONT_LIMIT, 16'd12800));
    plan.push_back(chk_row(25600, 20000, '{16'sd0, -16'sd32767, 1'b1, 1'b1, 1'b0, 1'b1}));
    plan.push_back(reg_row(pidsl_pkg::REG_BACK_LIMIT, 16'd6400));
    plan.push_back(chk_row(0, 3000, '{16'sd0, 16'sd32767, 1'b1, 1'b0, 1'b1, 1'b1}));
    plan.push_back(reg_row(pidsl_pkg::REG_FRONT_LIMIT, 16'd0));
    plan.push_back(reg_row(pidsl_pkg::REG_BACK_LIMIT, 16'd25600));
    plan.push_back(chk_row(100, 100, '{16'sd0, 16'sd0, 1'b0, 1'b1, 1'b1, 1'b1}));
    plan.push_back(reg_row(pidsl_pkg::REG_MIN_OUTPUT, 16'd1000));
    plan.push_back(reg_row(pidsl_pkg::REG_MAX_OUTPUT, 16'hFC18));
    plan.push_back(chk_row(100, 100, '{16'sd0, 16'sd1000, 1'b1, 1'b1, 1'b1, 1'b1}));
    plan.push_back(reg_row(pidsl_pkg::REG_MIN_OUTPUT, 16'h8000));
    plan.push_back(reg_row(pidsl_pkg::REG_MAX_OUTPUT, 16'h7FFF));
    plan.push_back(reg_row(pidsl_pkg::REG_FRONT_LIMIT, 16'd25600));
    plan.push_back(reg_row(pidsl_pkg::REG_BACK_LIMIT, 16'd0));
    plan.push_back(reg_row(pidsl_pkg::REG_KP_GAIN, 16'h8000));
    plan.push_back(chk_row(25600, 0, '{16'sd32767, 16'sd32767, 1'b0, 1'b0, 1'b1, 1'b1}));
    plan.push_back(reg_row(pidsl_pkg::REG_KP_GAIN, 16'h0000));
    plan.push_back(reg_row(pidsl_pkg::REG_KI_GAIN, 16'h7FFF));
    for (int i = 0; i < 6; i++) plan.push_back(smp_row(25600, 0));
    plan.push_back(reg_row(pidsl_pkg::REG_INTEGRAL_ZONE, 16'd256));
    plan.push_back(reg_row(pidsl_pkg::REG_KD_GAIN, 16'h7FFF));
    plan.push_back(smp_row(25600, 0));
    plan.push_back(smp_row(200, 0));
    plan.push_back(reg_row(pidsl_pkg::REG_KD_GAIN, 16'h8000));
    plan.push_back(smp_row(0, 32767));
    plan.push_back(smp_row(32767, 0));
    plan.push_back(reg_row(TOP_REG_CODE, 16'hFFFF));
    plan.push_back(smp_row(12800, 12900));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    prev_kind = ROW_REG;
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        if (prev_kind == ROW_SAMPLE) settle();
        put_reg(plan[i].idx, plan[i].wdata);
      end else begin
        if (prev_kind == ROW_REG) cfg_if.valid <= 1'b0;
        put_sample(plan[i].smp, plan[i].fixed, plan[i].want);
      end
      prev_kind = plan[i].kind;
    end
    settle();

    for (int ph = 0; ph < 8; ph++) begin
      gaps_on = (ph != 3);
      put_reg(pidsl_pkg::REG_KP_GAIN, pick_gain());
      put_reg(pidsl_pkg::REG_KI_GAIN, pick_gain());
      put_reg(pidsl_pkg::REG_KD_GAIN, pick_gain());
      case ($urandom_range(0, 3))
        0, 1: zone = 16'd0;
        2: zone = pick_pos();
        default: zone = 16'($urandom_range(0, 2048));
      endcase
      put_reg(pidsl_pkg::REG_INTEGRAL_ZONE, zone);
      lo = -int'($urandom_range(0, 32768));
      hi = int'($urandom_range(0, 32767));
      if ($urandom_range(0, 7) == 0) begin
        put_reg(pidsl_pkg::REG_MIN_OUTPUT, 16'(hi));
        put_reg(pidsl_pkg::REG_MAX_OUTPUT, 16'(lo));
      end else begin
        put_reg(pidsl_pkg::REG_MIN_OUTPUT, 16'(lo));
        put_reg(pidsl_pkg::REG_MAX_OUTPUT, 16'(hi));
      end
      put_reg(pidsl_pkg::REG_FRONT_LIMIT, ($urandom_range(0, 3) == 0) ? pick_pos() :
                                          16'($urandom_range(12800, 25600)));
      put_reg(pidsl_pkg::REG_BACK_LIMIT, ($urandom_range(0, 3) == 0) ? pick_pos() :
                                         16'($urandom_range(0, 12800)));
      if ($urandom_range(0, 1) == 1) begin
        put_reg(TOP_REG_CODE - 4'($urandom_range(0, 7)), 16'($urandom));
      end
      cfg_if.valid <= 1'b0;

      for (int k = 0; k < 60; k++) begin
        if (k == 0 || $urandom_range(0, 9) == 0) begin
          fld = pick_pos();
          tgt = int'(fld[14:0]);
          case ($urandom_range(0, 3))
            0: spread = 4;
            1: spread = 64;
            2: spread = 512;
            default: spread = 4096;
          endcase
        end
        if ($urandom_range(0, 9) == 0) begin
          fld = pick_pos();
          s.target_position = fld[14:0];
          fld = pick_pos();
          s.measured_position = fld[14:0];
        end else begin
          m = tgt + int'($urandom_range(0, 2 * spread)) - spread;
          if (m < 0) m = 0;
          if (m > 32767) m = 32767;
          s.target_position   = 15'(tgt);
          s.measured_position = 15'(m);
        end
        put_sample(s, 1'b0, '0);
      end
      settle();
    end

    repeat (8) @(posedge clk);
    if (pending_drive.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", pending_drive.size()));
    end

    $display("tb_top: %0d samples sent, %0d results checked, %0d register writes",
             samples_sent, drives_checked, reg_writes);
    $display("tb_top: %0d drives held off by a soft limit, %0d mismatches",
             drives_blocked, err_count);
    if (err_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_top: timed out with %0d results outstanding", pending_drive.size());
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
